>>> rtl/dalsc_pkg.sv
package dalsc_pkg;

   localparam int unsigned POS_W   = 16;
   localparam int unsigned DELTA_W = 32;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned CSR_A_W = 2;
   localparam int unsigned REQ_W   = 72;
   localparam int unsigned RSP_W   = 40;

   localparam logic [CSR_W-1:0] FOCUS_LIMIT_RST = 16'd25000;
   localparam logic [CSR_W-1:0] ZOOM_LIMIT_RST  = 16'd10000;
   localparam logic [CSR_W-1:0] PULSE_TICKS_RST = 16'd1000;
   localparam logic             ENABLE_RST      = 1'b1;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_ENABLE     = 3'd1,
      OP_MOVE_FOCUS = 3'd2,
      OP_MOVE_ZOOM  = 3'd3,
      OP_MOVE_BOTH  = 3'd4,
      OP_ZERO_FOCUS = 3'd5,
      OP_ZERO_ZOOM  = 3'd6
   } op_type;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_FOCUS_LIMIT = 2'd0,
      CSR_ZOOM_LIMIT  = 2'd1,
      CSR_FOCUS_TICKS = 2'd2,
      CSR_ZOOM_TICKS  = 2'd3
   } csr_idx_type;

   // one of these per axis per word; at most one is set
   typedef struct packed {
      logic tick;
      logic move;
      logic zero;
   } axis_ctl_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             level;
      logic             dir;
      logic             busy;
   } axis_view_type;

endpackage

>>> rtl/dalsc_axis.sv
module dalsc_axis
   import dalsc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  axis_ctl_type              ctl,
   input  logic signed [DELTA_W-1:0] delta,
   input  logic [POS_W-1:0]          limit,
   input  logic [POS_W-1:0]          pulse_ticks,
   output axis_view_type             cur,
   output axis_view_type             nxt
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] rem_ff, rem_in;
   logic [POS_W-1:0] timer_ff, timer_in;
   logic             level_ff, level_in;
   logic             dir_ff, dir_in;

   logic signed [DELTA_W+1:0] want;
   logic [POS_W-1:0]          target;
   logic [POS_W-1:0]          travel;
   logic [POS_W-1:0]          reload;

   // clamp the requested position into [0, limit]
   always_comb begin
      want = $signed({{(DELTA_W+2-POS_W){1'b0}}, pos_ff})
           + $signed({{2{delta[DELTA_W-1]}}, delta});
      if (want[DELTA_W+1]) begin
         target = '0;
      end else if (want > $signed({{(DELTA_W+2-POS_W){1'b0}}, limit})) begin
         target = limit;
      end else begin
         target = want[POS_W-1:0];
      end
      travel = (pos_ff >= target) ? (pos_ff - target) : (target - pos_ff);
      reload = (pulse_ticks == '0) ? '0 : (pulse_ticks - POS_W'(1));
   end

   always_comb begin
      pos_in   = pos_ff;
      rem_in   = rem_ff;
      timer_in = timer_ff;
      level_in = level_ff;
      dir_in   = dir_ff;
      if (ctl.move) begin
         pos_in   = target;
         rem_in   = travel;
         timer_in = '0;
         level_in = 1'b0;
         dir_in   = delta[DELTA_W-1];
      end else if (ctl.zero) begin
         pos_in   = '0;
         rem_in   = pos_ff;
         timer_in = '0;
         level_in = 1'b0;
         dir_in   = 1'b1;
      end else if (ctl.tick && (rem_ff != '0)) begin
         if (timer_ff == '0) begin
            level_in = ~level_ff;
            timer_in = reload;
         end else begin
            timer_in = timer_ff - POS_W'(1);
         end
         // step done at the end of the low half
         if (!level_in && (timer_in == '0)) begin
            rem_in = rem_ff - POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         rem_ff   <= '0;
         timer_ff <= '0;
         level_ff <= 1'b0;
         dir_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         rem_ff   <= rem_in;
         timer_ff <= timer_in;
         level_ff <= level_in;
         dir_ff   <= dir_in;
      end
   end

   assign cur = '{pos: pos_ff, level: level_ff, dir: dir_ff, busy: (rem_ff != '0)};
   assign nxt = '{pos: pos_in, level: level_in, dir: dir_in, busy: (rem_in != '0)};

endmodule

>>> rtl/dual_axis_limited_stepper_control_core.sv
// Two-axis step/direction controller (focus and zoom) with soft position limits.
// Each request word is a tick, an enable write, a move (focus, zoom or both) or a
// zero command; each gives exactly one response word holding the state after it.
// In the update stage, a request register feeds the clamp/count logic, which
// writes the axis state and the response register in the same cycle, so one
// word per clock is sustained while rsp_tready is high. Moves or zeros on an
// axis with pulses outstanding are refused (accepted = 0). Step pulses advance
// only on tick words: high for pulse_ticks ticks, then low for as many.
module dual_axis_limited_stepper_control_core
   import dalsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // [31:0] focus_delta, [63:32] zoom_delta, [64] enable_value, rest zero
   input  logic [REQ_W-1:0]   req_tdata,
   // [2:0] operation
   input  logic [2:0]         req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // [0] accepted, [16:1] focus_position, [32:17] zoom_position,
   // [33] focus_step_out, [34] zoom_step_out, [35] focus_dir_out,
   // [36] zoom_dir_out, [37] enable_out, [38] focus_busy, [39] zoom_busy
   output logic [RSP_W-1:0]   rsp_tdata,
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata
);

   logic [CSR_W-1:0] focus_limit_ff, zoom_limit_ff, focus_ticks_ff, zoom_ticks_ff;

   logic                      in_vld_ff;
   op_type                    op_ff;
   logic signed [DELTA_W-1:0] fdelta_ff, zdelta_ff;
   logic                      en_val_ff;

   logic             rsp_vld_ff, rsp_vld_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             enable_ff, enable_in;

   logic          advance;
   logic          acc;
   axis_ctl_type  fctl, zctl;
   axis_view_type fcur, fnxt, zcur, znxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         focus_limit_ff <= FOCUS_LIMIT_RST;
         zoom_limit_ff  <= ZOOM_LIMIT_RST;
         focus_ticks_ff <= PULSE_TICKS_RST;
         zoom_ticks_ff  <= PULSE_TICKS_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_FOCUS_LIMIT: focus_limit_ff <= csr_wdata;
            CSR_ZOOM_LIMIT:  zoom_limit_ff  <= csr_wdata;
            CSR_FOCUS_TICKS: focus_ticks_ff <= csr_wdata;
            CSR_ZOOM_TICKS:  zoom_ticks_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         op_ff     <= op_type'(req_tuser);
         fdelta_ff <= req_tdata[31:0];
         zdelta_ff <= req_tdata[63:32];
         en_val_ff <= req_tdata[64];
      end
   end

   // command decode; busy is judged on the state before the word
   always_comb begin
      acc       = 1'b0;
      fctl      = '0;
      zctl      = '0;
      enable_in = enable_ff;
      case (op_ff)
         OP_TICK: begin
            acc       = 1'b1;
            fctl.tick = 1'b1;
            zctl.tick = 1'b1;
         end
         OP_ENABLE: begin
            acc       = 1'b1;
            enable_in = en_val_ff;
         end
         OP_MOVE_FOCUS: begin
            acc       = !fcur.busy;
            fctl.move = !fcur.busy;
         end
         OP_MOVE_ZOOM: begin
            acc       = !zcur.busy;
            zctl.move = !zcur.busy;
         end
         OP_MOVE_BOTH: begin
            acc       = !fcur.busy && !zcur.busy;
            fctl.move = acc;
            zctl.move = acc;
         end
         OP_ZERO_FOCUS: begin
            acc       = !fcur.busy;
            fctl.zero = !fcur.busy;
         end
         OP_ZERO_ZOOM: begin
            acc       = !zcur.busy;
            zctl.zero = !zcur.busy;
         end
         default: ;
      endcase
      if (!advance) begin
         fctl      = '0;
         zctl      = '0;
         enable_in = enable_ff;
      end
   end

   dalsc_axis u_focus (
      .clock       (clock),
      .reset       (reset),
      .ctl         (fctl),
      .delta       (fdelta_ff),
      .limit       (focus_limit_ff),
      .pulse_ticks (focus_ticks_ff),
      .cur         (fcur),
      .nxt         (fnxt)
   );

   dalsc_axis u_zoom (
      .clock       (clock),
      .reset       (reset),
      .ctl         (zctl),
      .delta       (zdelta_ff),
      .limit       (zoom_limit_ff),
      .pulse_ticks (zoom_ticks_ff),
      .cur         (zcur),
      .nxt         (znxt)
   );

   always_comb begin
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = {znxt.busy, fnxt.busy, enable_in, znxt.dir, fnxt.dir,
                        znxt.level, fnxt.level, znxt.pos, fnxt.pos, acc};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         enable_ff  <= ENABLE_RST;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         enable_ff  <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // a step level can only be high while pulses are outstanding
   a_focus_level_busy: assert property (@(posedge clock) disable iff (reset)
      (!fcur.level || fcur.busy))
      else $error("focus step high while idle");

   a_zoom_level_busy: assert property (@(posedge clock) disable iff (reset)
      (!zcur.level || zcur.busy))
      else $error("zoom step high while idle");

   // a held request word keeps its command until the update stage takes it
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(op_ff) && $stable(fdelta_ff)))
      else $error("request stage lost a word");

   // a tick word is always reported as carried out
   a_tick_acc: assert property (@(posedge clock) disable iff (reset)
      (advance && (op_ff == OP_TICK)) |=> (rsp_tvalid && rsp_tdata[0]))
      else $error("tick word not accepted");

   // motors come out of reset enabled
   a_enable_reset: assert property (@(posedge clock)
      reset |=> enable_ff)
      else $error("enable level wrong after reset");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import dalsc_pkg::*;

   localparam int          CYCLE_LIMIT = 200000;
   localparam logic [2:0]  OP_UNUSED   = 3'd7;

   typedef struct {
      logic [15:0] pos;
      logic [15:0] remaining;
      logic [15:0] timer;
      logic [15:0] limit;
      logic [15:0] pulse_len;
      logic        level;
      logic        dir;
   } axis_state_type;

   // same layout as rsp_tdata, highest field first
   typedef struct packed {
      logic        zoom_busy;
      logic        focus_busy;
      logic        motor_en;
      logic        zoom_dir;
      logic        focus_dir;
      logic        zoom_step;
      logic        focus_step;
      logic [15:0] zoom_pos;
      logic [15:0] focus_pos;
      logic        accepted;
   } stepper_status_type;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // [31:0] focus_delta, [63:32] zoom_delta, [64] enable_value, rest zero
   logic [REQ_W-1:0] req_tdata  = '0;
   // [2:0] operation
   logic [2:0]       req_tuser  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // [0] accepted, [16:1] focus_position, [32:17] zoom_position,
   // [33] focus_step_out, [34] zoom_step_out, [35] focus_dir_out,
   // [36] zoom_dir_out, [37] enable_out, [38] focus_busy, [39] zoom_busy
   logic [RSP_W-1:0] rsp_tdata;
   logic               csr_we    = 1'b0;
   logic [CSR_A_W-1:0] csr_addr  = '0;
   logic [CSR_W-1:0]   csr_wdata = '0;

   axis_state_type     focus_ax, zoom_ax;
   logic               motor_en_level;
   stepper_status_type pending_status[$];
   stepper_status_type got_status, want_status;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   int mismatches = 0;
   int cycle_count = 0;

   dual_axis_limited_stepper_control_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------- step/position predictor ----------------

   function automatic void axis_advance(inout axis_state_type a);
      logic [15:0] len;
      len = (a.pulse_len == 16'd0) ? 16'd1 : a.pulse_len;
      if (a.remaining == 16'd0)
         return;
      if (a.timer == 16'd0) begin
         a.level = ~a.level;
         a.timer = len - 16'd1;
      end else begin
         a.timer = a.timer - 16'd1;
      end
      if (!a.level && a.timer == 16'd0)
         a.remaining = a.remaining - 16'd1;
   endfunction

   function automatic void axis_shift(inout axis_state_type a, input logic [31:0] raw);
      longint delta, want, steps;
      delta = longint'($signed(raw));
      want  = longint'(a.pos) + delta;
      steps = delta;
      if (want < 0)
         steps = -longint'(a.pos);
      else if (want > longint'(a.limit))
         steps = longint'(a.limit) - longint'(a.pos);
      // direction follows the request even when the clamp flips the sign
      a.dir       = raw[31];
      a.pos       = a.pos + steps[15:0];
      a.remaining = (steps < 0) ? 16'(-steps) : 16'(steps);
      a.timer     = 16'd0;
      a.level     = 1'b0;
   endfunction

   function automatic void axis_home(inout axis_state_type a);
      a.dir       = 1'b1;
      a.remaining = a.pos;
      a.pos       = 16'd0;
      a.timer     = 16'd0;
      a.level     = 1'b0;
   endfunction

   function automatic stepper_status_type predict_status(logic [2:0] op, logic [31:0] fd,
                                                         logic [31:0] zd, logic en);
      stepper_status_type s;
      logic fb, zb, ok;
      fb = (focus_ax.remaining != 16'd0);
      zb = (zoom_ax.remaining != 16'd0);
      ok = 1'b0;
      case (op)
         OP_TICK: begin
            axis_advance(focus_ax);
            axis_advance(zoom_ax);
            ok = 1'b1;
         end
         OP_ENABLE: begin
            motor_en_level = en;
            ok = 1'b1;
         end
         OP_MOVE_FOCUS: if (!fb) begin
            axis_shift(focus_ax, fd);
            ok = 1'b1;
         end
         OP_MOVE_ZOOM: if (!zb) begin
            axis_shift(zoom_ax, zd);
            ok = 1'b1;
         end
         OP_MOVE_BOTH: if (!fb && !zb) begin
            axis_shift(focus_ax, fd);
            axis_shift(zoom_ax, zd);
            ok = 1'b1;
         end
         OP_ZERO_FOCUS: if (!fb) begin
            axis_home(focus_ax);
            ok = 1'b1;
         end
         OP_ZERO_ZOOM: if (!zb) begin
            axis_home(zoom_ax);
            ok = 1'b1;
         end
         default: ;
      endcase
      s.accepted   = ok;
      s.focus_pos  = focus_ax.pos;
      s.zoom_pos   = zoom_ax.pos;
      s.focus_step = focus_ax.level;
      s.zoom_step  = zoom_ax.level;
      s.focus_dir  = focus_ax.dir;
      s.zoom_dir   = zoom_ax.dir;
      s.motor_en   = motor_en_level;
      s.focus_busy = (focus_ax.remaining != 16'd0);
      s.zoom_busy  = (zoom_ax.remaining != 16'd0);
      return s;
   endfunction

   // ---------------- driving ----------------

   task automatic send_word(logic [2:0] op, logic [31:0] fd, logic [31:0] zd, logic en);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, en, zd, fd};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_status.push_back(predict_status(op, fd, zd, en));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_axes(logic [15:0] fl, logic [15:0] zl, logic [15:0] ft,
                               logic [15:0] zt);
      logic [15:0] vals[4];
      vals = '{fl, zl, ft, zt};
      drain();
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= CSR_A_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      focus_ax.limit     = fl;
      zoom_ax.limit      = zl;
      focus_ax.pulse_len = ft;
      zoom_ax.pulse_len  = zt;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_delta(logic [15:0] lim);
      // full-range deltas only where the clamp keeps the pulse count short
      if (lim <= 16'd200 && $urandom_range(99) < 15)
         return $urandom;
      return 32'(int'($urandom_range(24)) - 12);
   endfunction

   task automatic send_random(int count);
      logic [2:0] op;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 50)      op = OP_TICK;
         else if (r < 55) op = OP_ENABLE;
         else if (r < 67) op = OP_MOVE_FOCUS;
         else if (r < 79) op = OP_MOVE_ZOOM;
         else if (r < 89) op = OP_MOVE_BOTH;
         else if (r < 94) op = OP_ZERO_FOCUS;
         else if (r < 99) op = OP_ZERO_ZOOM;
         else             op = OP_UNUSED;
         send_word(op, pick_delta(focus_ax.limit), pick_delta(zoom_ax.limit),
                   1'($urandom_range(1)));
      end
   endtask

   // ---------------- response side ----------------

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
      if (exp !== act) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", name, exp, act);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = rsp_tdata;
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word %h", rsp_tdata);
         end else begin
            want_status = pending_status.pop_front();
            check_field("accepted",   want_status.accepted,   got_status.accepted);
            check_field("focus_pos",  want_status.focus_pos,  got_status.focus_pos);
            check_field("zoom_pos",   want_status.zoom_pos,   got_status.zoom_pos);
            check_field("focus_step", want_status.focus_step, got_status.focus_step);
            check_field("zoom_step",  want_status.zoom_step,  got_status.zoom_step);
            check_field("focus_dir",  want_status.focus_dir,  got_status.focus_dir);
            check_field("zoom_dir",   want_status.zoom_dir,   got_status.zoom_dir);
            check_field("enable",     want_status.motor_en,   got_status.motor_en);
            check_field("focus_busy", want_status.focus_busy, got_status.focus_busy);
            check_field("zoom_busy",  want_status.zoom_busy,  got_status.zoom_busy);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------- tests ----------------

   task automatic test_reset_state();
      send_word(OP_TICK, 32'd0, 32'd0, 1'b0);
      send_word(OP_ENABLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_word(OP_ENABLE, 32'd0, 32'd0, 1'b1);
      send_word(OP_UNUSED, 32'd5, 32'd5, 1'b1);
      send_word(OP_ZERO_ZOOM, 32'd0, 32'd0, 1'b0);
      send_word(OP_MOVE_BOTH, 32'd0, 32'd0, 1'b0);
   endtask

   // pulse length 0 on focus behaves as 1
   task automatic test_clamp_and_refusal();
      program_axes(16'd5, 16'd3, 16'd0, 16'd1);
      send_word(OP_MOVE_BOTH, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_word(OP_MOVE_FOCUS, 32'd1, 32'd0, 1'b0);
      send_word(OP_MOVE_BOTH, 32'd1, 32'd1, 1'b0);
      send_word(OP_ZERO_FOCUS, 32'd0, 32'd0, 1'b0);
      send_word(OP_MOVE_ZOOM, 32'd0, 32'd3, 1'b0);
      send_word(OP_ZERO_ZOOM, 32'd0, 32'd0, 1'b0);
      repeat (10) send_word(OP_TICK, $urandom, $urandom, 1'($urandom_range(1)));
   endtask

   // limit dropped under the position: the clamp reverses travel, dir stays as asked
   task automatic test_lowered_limit();
      program_axes(16'd2, 16'd1, 16'd1, 16'd1);
      send_word(OP_MOVE_FOCUS, 32'd1, 32'd0, 1'b0);
      send_word(OP_MOVE_ZOOM, 32'd0, 32'hFFFF_FFFF, 1'b0);
      send_word(OP_TICK, 32'd0, 32'd0, 1'b0);
      send_word(OP_TICK, 32'd0, 32'd0, 1'b0);
   endtask

   task automatic test_random_phase(int idle, int stall, logic [15:0] fl, logic [15:0] zl,
                                    logic [15:0] ft, logic [15:0] zt, int count);
      program_axes(fl, zl, ft, zt);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      send_random(count);
   endtask

   task automatic test_backpressure();
      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 300;
      send_random(40);
   endtask

   task automatic test_long_pulse();
      program_axes(16'd100, 16'd100, 16'hFFFF, 16'hFFFF);
      send_word(OP_ZERO_FOCUS, 32'd0, 32'd0, 1'b0);
      send_word(OP_MOVE_BOTH, 32'd1, 32'd1, 1'b1);
      repeat (3) send_word(OP_TICK, 32'd0, 32'd0, 1'b0);
   endtask

   initial begin
      focus_ax       = '{16'd0, 16'd0, 16'd0, FOCUS_LIMIT_RST, PULSE_TICKS_RST, 1'b0, 1'b0};
      zoom_ax        = '{16'd0, 16'd0, 16'd0, ZOOM_LIMIT_RST, PULSE_TICKS_RST, 1'b0, 1'b0};
      motor_en_level = ENABLE_RST;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_clamp_and_refusal();
      test_lowered_limit();
      test_random_phase(0, 0, 16'd40, 16'd25, 16'd1, 16'd2, 210);
      test_random_phase(88, 0, 16'd0, 16'd7, 16'd3, 16'd1, 210);
      test_random_phase(0, 88, 16'hFFFF, 16'd30, 16'd2, 16'd2, 210);
      test_random_phase(11, 11, 16'd20, 16'hFFFF, 16'd1, 16'd3, 210);
      test_backpressure();
      test_long_pulse();

      drain();
      if (mismatches == 0 && pending_status.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/dalsc_pkg.sv
rtl/dalsc_axis.sv
rtl/dual_axis_limited_stepper_control_core.sv
tb/sv/testbench.sv
